// ===== hw/rtl/mbb_pkg.sv =====
package mbb_pkg;

   localparam int CURSOR_W = 16;
   localparam int DATA_W   = 32;
   localparam int ACT_W    = 3;
   localparam int COUNT_W  = 6;   // bit count 0..32
   localparam int SPAN_W   = 6;   // bit offset plus bit count, 0..39
   localparam int NBYTE_W  = 3;   // byte count 1..4
   localparam int ACC_W    = 40;  // up to five bytes gathered for one read

   // operation codes carried by req_action
   localparam logic [ACT_W-1:0] ACT_INIT        = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SKIP        = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ_BITS   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ_BYTES  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_WRITE_BYTES = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALIGN,
      ST_MOD,
      ST_FETCH,
      ST_WRITE,
      ST_DONE
   } mbb_state_type;

   // byte count limited to 1..4
   function automatic logic [NBYTE_W-1:0] clamp_bytes(input logic [CURSOR_W-1:0] n);
      logic [NBYTE_W-1:0] r;
      if (n == '0) begin
         r = 3'd1;
      end else if (n > 16'd4) begin
         r = 3'd4;
      end else begin
         r = n[NBYTE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mbb_ram.sv =====
module mbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mbb_mod.sv =====
module mbb_mod import mbb_pkg::*; #(
   parameter int MODULUS = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [CURSOR_W-1:0]        value,
   output logic                       done,
   output logic [$clog2(MODULUS)-1:0] result
);

   localparam int RW = $clog2(MODULUS);
   localparam int PW = 2 * CURSOR_W + 1;
   // reciprocal scaled by 2^16, quotient estimate is at most one low
   localparam logic [CURSOR_W:0] RECIP   = (CURSOR_W+1)'((1 << CURSOR_W) / MODULUS);
   localparam logic [CURSOR_W:0] MOD_EXT = (CURSOR_W+1)'(MODULUS);

   logic [CURSOR_W-1:0] val_ff, val_in;
   logic [CURSOR_W-1:0] quot_ff, quot_in;
   logic [CURSOR_W:0]   diff_ff, diff_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [3:0]          stage_ff, stage_in;
   logic [PW-1:0]       prod_q, prod_back;

   // estimate quotient, subtract back, one final correction step
   always_comb begin
      val_in    = start ? value : val_ff;
      prod_q    = PW'(val_ff) * PW'(RECIP);
      quot_in   = prod_q[2*CURSOR_W-1:CURSOR_W];
      prod_back = PW'(quot_ff) * PW'(MOD_EXT);
      diff_in   = {1'b0, val_ff} - prod_back[CURSOR_W:0];
      if (diff_ff >= MOD_EXT) begin
         rem_in = RW'(diff_ff - MOD_EXT);
      end else begin
         rem_in = RW'(diff_ff);
      end
      stage_in  = {stage_ff[2:0], start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      val_ff  <= val_in;
      quot_ff <= quot_in;
      diff_ff <= diff_in;
      rem_ff  <= rem_in;
   end

   assign done   = stage_ff[3];
   assign result = rem_ff;

endmodule

// ===== hw/rtl/msb_first_bitstream_buffer.sv =====
// MSB-first bitstream buffer: a byte store with a read cursor (byte and bit
// part) and a byte write cursor, driven one operation per request beat.
// Request channel req_*: action, amount and write data; every request beat
// yields exactly one response beat on rsp_* carrying the value read and the
// end-of-data flag as seen after the operation.
// Steps per operation, from request beat to response valid:
//   read bits    one byte-memory read issued per cycle for each byte
//                touched (up to five), each read registered in the memory;
//                no read when no byte is touched
//   read bytes   an align step to the next byte boundary, then as read bits
//   write bytes  one byte-memory write per cycle
//   init, skip   a pass through the remainder unit that maps a cursor to a
//                buffer address; skip first aligns and moves the cursor
// One request is in work at a time; the response sits in an output register,
// so a new request is taken while the previous response is still stalled.
// A stalled response only holds up the operation after it, at its end.
// After reset the whole buffer is swept to zero, one byte per cycle;
// req_ready stays low during that sweep.
module msb_first_bitstream_buffer import mbb_pkg::*; #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACT_W-1:0]    req_action,
   input  logic [CURSOR_W-1:0] req_amount,
   input  logic [DATA_W-1:0]   req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_read_value,
   output logic                rsp_at_end
);

   localparam int SW = $clog2(BUFFER_BYTES);
   localparam logic [SW-1:0] LAST_SLOT = SW'(BUFFER_BYTES - 1);

   mbb_state_type state_ff, state_in;

   logic [ACT_W-1:0]    op_ff, op_in;
   logic [CURSOR_W-1:0] amount_ff, amount_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [SPAN_W-1:0]   span_ff, span_in;
   logic [NBYTE_W-1:0]  wcnt_ff, wcnt_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic [2:0]          issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SW-1:0]       clr_addr_ff, clr_addr_in;

   logic [CURSOR_W-1:0] rd_cursor_ff, rd_cursor_in;
   logic [2:0]          rd_off_ff, rd_off_in;
   logic [SW-1:0]       rd_slot_ff, rd_slot_in;
   logic [CURSOR_W-1:0] wr_cursor_ff, wr_cursor_in;
   logic [SW-1:0]       wr_slot_ff, wr_slot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_end_ff, rsp_end_in;

   logic                ram_wr_en, ram_rd_en;
   logic [SW-1:0]       ram_wr_addr;
   logic [7:0]          ram_wr_data, ram_rd_data;

   logic                mod_start, mod_done;
   logic [CURSOR_W-1:0] mod_value;
   logic [SW-1:0]       mod_result;

   logic [NBYTE_W-1:0]  req_nbytes;
   logic [COUNT_W-1:0]  req_bits;
   logic [SPAN_W-1:0]   span_up;
   logic [2:0]          fetch_total, fetch_used;
   logic                fetch_end;
   logic [SW-1:0]       rd_slot_next, wr_slot_next;
   logic [2:0]          extract_sh;
   logic [ACC_W-1:0]    acc_shifted;
   logic [DATA_W:0]     bit_mask;
   logic [DATA_W-1:0]   extract_value;
   logic [CURSOR_W:0]   rd_pos;
   logic                out_free;

   // request decode
   assign req_nbytes = clamp_bytes(req_amount);
   assign req_bits   = (req_amount > 16'd32) ? 6'd32 : req_amount[COUNT_W-1:0];

   // bytes touched and bytes fully consumed by the current read
   assign span_up     = span_ff + 6'd7;
   assign fetch_total = span_up[5:3];
   assign fetch_used  = span_ff[5:3];
   assign fetch_end   = (issue_ff == fetch_total) && !pend_ff;

   // address of the next byte, with wrap at buffer end and at cursor wrap
   assign rd_slot_next = (rd_cursor_ff == '1 || rd_slot_ff == LAST_SLOT) ?
                         '0 : rd_slot_ff + 1'b1;
   assign wr_slot_next = (wr_cursor_ff == '1 || wr_slot_ff == LAST_SLOT) ?
                         '0 : wr_slot_ff + 1'b1;

   // right-align the wanted bits out of the gathered bytes
   assign extract_sh    = 3'd0 - span_ff[2:0];
   assign acc_shifted   = acc_ff >> extract_sh;
   assign bit_mask      = (33'd1 << cnt_ff) - 33'd1;
   assign extract_value = acc_shifted[DATA_W-1:0] & bit_mask[DATA_W-1:0];

   // end test on the rounded-up read position
   assign rd_pos   = {1'b0, rd_cursor_ff} + {16'd0, (rd_off_ff != 3'd0)};
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_INIT:        state_in = ST_MOD;
                  ACT_SKIP:        state_in = ST_ALIGN;
                  ACT_READ_BITS:   state_in = ST_FETCH;
                  ACT_READ_BYTES:  state_in = ST_ALIGN;
                  ACT_WRITE_BYTES: state_in = ST_WRITE;
                  default:         state_in = ST_DONE;
               endcase
            end
         end
         ST_ALIGN: begin
            state_in = (op_ff == ACT_SKIP) ? ST_MOD : ST_FETCH;
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_DONE;
            end
         end
         ST_FETCH: begin
            if (fetch_end) begin
               state_in = ST_DONE;
            end
         end
         ST_WRITE: begin
            if (wcnt_ff == 3'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in        = op_ff;
      amount_in    = amount_ff;
      cnt_in       = cnt_ff;
      span_in      = span_ff;
      wcnt_in      = wcnt_ff;
      wdata_in     = wdata_ff;
      issue_in     = issue_ff;
      acc_in       = acc_ff;
      clr_addr_in  = clr_addr_ff;
      rd_cursor_in = rd_cursor_ff;
      rd_off_in    = rd_off_ff;
      rd_slot_in   = rd_slot_ff;
      wr_cursor_in = wr_cursor_ff;
      wr_slot_in   = wr_slot_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_slot_ff;
      ram_wr_data  = wdata_ff[DATA_W-1 -: 8];
      ram_rd_en    = 1'b0;
      mod_start    = 1'b0;
      mod_value    = req_amount;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 8'd0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_action;
               amount_in = req_amount;
               wcnt_in   = req_nbytes;
               issue_in  = 3'd0;
               acc_in    = '0;
               cnt_in    = (req_action == ACT_READ_BITS) ? req_bits : {req_nbytes, 3'd0};
               span_in   = {3'd0, rd_off_ff} + req_bits;
               // left-justify the bytes to be written
               case (req_nbytes)
                  3'd1:    wdata_in = {req_write_data[7:0], 24'd0};
                  3'd2:    wdata_in = {req_write_data[15:0], 16'd0};
                  3'd3:    wdata_in = {req_write_data[23:0], 8'd0};
                  default: wdata_in = req_write_data;
               endcase
               if (req_action == ACT_INIT) begin
                  wr_cursor_in = req_amount;
                  rd_cursor_in = '0;
                  rd_off_in    = 3'd0;
                  rd_slot_in   = '0;
                  mod_start    = 1'b1;
                  mod_value    = req_amount;
               end
            end
         end
         ST_ALIGN: begin
            rd_off_in = 3'd0;
            if (op_ff == ACT_SKIP) begin
               rd_cursor_in = rd_cursor_ff + {15'd0, (rd_off_ff != 3'd0)} + amount_ff;
               mod_start    = 1'b1;
               mod_value    = rd_cursor_in;
            end else begin
               span_in = cnt_ff;
               if (rd_off_ff != 3'd0) begin
                  rd_cursor_in = rd_cursor_ff + 1'b1;
                  rd_slot_in   = rd_slot_next;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               if (op_ff == ACT_INIT) begin
                  wr_slot_in = mod_result;
               end else begin
                  rd_slot_in = mod_result;
               end
            end
         end
         ST_FETCH: begin
            // issue one byte read per cycle, advance past consumed bytes only
            if (issue_ff != fetch_total) begin
               ram_rd_en = 1'b1;
               issue_in  = issue_ff + 1'b1;
               if (issue_ff < fetch_used) begin
                  rd_cursor_in = rd_cursor_ff + 1'b1;
                  rd_slot_in   = rd_slot_next;
               end
            end
            if (pend_ff) begin
               acc_in = {acc_ff[ACC_W-9:0], ram_rd_data};
            end
            if (fetch_end) begin
               rd_off_in = span_ff[2:0];
            end
         end
         ST_WRITE: begin
            ram_wr_en    = 1'b1;
            wdata_in     = {wdata_ff[DATA_W-9:0], 8'd0};
            wr_cursor_in = wr_cursor_ff + 1'b1;
            wr_slot_in   = wr_slot_next;
            wcnt_in      = wcnt_ff - 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = (rd_pos >= {1'b0, wr_cursor_ff});
               rsp_value_in = (op_ff == ACT_READ_BITS || op_ff == ACT_READ_BYTES) ?
                              extract_value : '0;
            end
         end
         default: begin
         end
      endcase
      pend_in = ram_rd_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         rd_cursor_ff <= '0;
         rd_off_ff    <= 3'd0;
         rd_slot_ff   <= '0;
         wr_cursor_ff <= '0;
         wr_slot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         rd_cursor_ff <= rd_cursor_in;
         rd_off_ff    <= rd_off_in;
         rd_slot_ff   <= rd_slot_in;
         wr_cursor_ff <= wr_cursor_in;
         wr_slot_ff   <= wr_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      amount_ff    <= amount_in;
      cnt_ff       <= cnt_in;
      span_ff      <= span_in;
      wcnt_ff      <= wcnt_in;
      wdata_ff     <= wdata_in;
      issue_ff     <= issue_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // byte store
   mbb_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_slot_ff),
      .rd_data (ram_rd_data)
   );

   // cursor to buffer address after init or a skip
   mbb_mod #(
      .MODULUS (BUFFER_BYTES)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_at_end     = rsp_end_ff;

endmodule
